// ----- rtl/core/positional_array_list_core_macros.svh -----
// Assertion macros shared by the positional array list core.
`ifndef POSITIONAL_ARRAY_LIST_CORE_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PAL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pal assertion failed");

// Next-cycle implication, checked outside reset.
`define PAL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pal assertion failed");

`endif

// ----- rtl/core/pal_pkg.sv -----
// Types and constants of the positional array list core.
package pal_pkg;

  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned COUNT_W  = 7;

  typedef enum logic [1:0] {
    CMD_INSERT_AT  = 2'd0,
    CMD_REMOVE_AT  = 2'd1,
    CMD_INSERT_END = 2'd2,
    CMD_REMOVE_END = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic [HANDLE_W-1:0] removed_handle;
    status_e             status;
    logic [COUNT_W-1:0]  entry_count;
  } result_t;

endpackage

// ----- rtl/core/pal_cell.sv -----
// One list slot: holds a handle and shifts towards either neighbour.
module pal_cell import pal_pkg::*; #(
  parameter int unsigned INDEX       = 0,
  parameter int unsigned PW          = 7,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  logic                   clk_i,
  input  cell_op_e               op_i,
  input  logic [PW-1:0]          pos_i,
  input  logic [HANDLE_BITS-1:0] new_handle_i,
  input  logic [HANDLE_BITS-1:0] left_i,
  input  logic [HANDLE_BITS-1:0] right_i,
  output logic [HANDLE_BITS-1:0] data_o
);

  localparam logic [PW-1:0] Idx = PW'(INDEX);

  logic [HANDLE_BITS-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    case (op_i)
      OP_INSERT: begin
        if (Idx == pos_i) begin
          data_d = new_handle_i;
        end else if (Idx > pos_i) begin
          data_d = left_i;
        end
      end
      OP_REMOVE: begin
        if (Idx >= pos_i) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ----- rtl/core/pal_result_buf.sv -----
// Two-entry result queue between the list and the output channel.
module pal_result_buf import pal_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_valid_i,
  output logic    push_ready_o,
  input  result_t push_data_i,
  output logic    pop_valid_o,
  input  logic    pop_ready_i,
  output result_t pop_data_o
);

  logic [1:0] fill_d, fill_q;
  result_t    slot0_d, slot0_q, slot1_d, slot1_q;
  logic       push, pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    fill_d  = fill_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (push && pop) begin
      if (fill_q == 2'd1) begin
        slot0_d = push_data_i;
      end else begin
        slot0_d = slot1_q;
        slot1_d = push_data_i;
      end
    end else if (push) begin
      fill_d = fill_q + 2'd1;
      if (fill_q == 2'd0) begin
        slot0_d = push_data_i;
      end else begin
        slot1_d = push_data_i;
      end
    end else if (pop) begin
      fill_d  = fill_q - 2'd1;
      slot0_d = slot1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 2'd0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign pop_data_o = slot0_q;

endmodule

// ----- rtl/core/positional_array_list_core.sv -----
// Top level of the positional array list: command decode, slot chain and result queue.
//
// Usage: each beat on the input channel is one command (insert at a position,
// remove at a position, insert at the end, remove at the end) and yields
// exactly one result beat carrying the removed handle, a status and the new
// entry count. Failed commands report full, empty or out-of-range status and
// leave the list untouched; removed_handle is zero unless a remove succeeds.
// The list is a row of slot cells. The slot at the command position and all
// slots above it change in the same cycle, so a command is accepted every cycle
// while the result queue has room. The result enters the result queue as the
// command is accepted, and out_valid_o is high in the cycle after.
// A two-entry result queue decouples the sides: commands keep being taken
// while fewer than two results wait; with the queue full, in_ready_o drops until
// the receiver takes a beat. Reset empties the list and the queue at once;
// no clearing pass is needed, as only slots below the count are ever read.
module positional_array_list_core import pal_pkg::*; #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          cmd_i,
  input  logic [POS_W-1:0]    position_i,
  input  logic [HANDLE_W-1:0] item_handle_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [HANDLE_W-1:0] removed_handle_o,
  output logic [1:0]          status_o,
  output logic [COUNT_W-1:0]  entry_count_o
);

  `include "positional_array_list_core_macros.svh"

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned PW   = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned MINB = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

  logic [CW-1:0]          count_d, count_q;
  logic [PW-1:0]          pos_eff, cnt_ext;
  logic                   is_ins, do_cmd, in_acc;
  status_e                status;
  cell_op_e               op;
  logic [HANDLE_BITS-1:0] new_handle, sel;
  logic [HANDLE_BITS-1:0] cell_q [CAPACITY];
  result_t                res, out_res;

  assign cnt_ext    = PW'(count_q);
  assign new_handle = HANDLE_BITS'(item_handle_i[MINB-1:0]);

  always_comb begin
    pos_eff = '0;
    is_ins  = 1'b0;
    status  = ST_OK;
    case (cmd_e'(cmd_i))
      CMD_INSERT_AT: begin
        is_ins  = 1'b1;
        pos_eff = PW'(position_i);
      end
      CMD_REMOVE_AT: begin
        pos_eff = PW'(position_i);
      end
      CMD_INSERT_END: begin
        is_ins  = 1'b1;
        pos_eff = cnt_ext;
      end
      CMD_REMOVE_END: begin
        pos_eff = PW'(count_q - CW'(1));
      end
      default: pos_eff = '0;
    endcase
    if (is_ins) begin
      if (count_q == CW'(CAPACITY)) begin
        status = ST_FULL;
      end else if (pos_eff > cnt_ext) begin
        status = ST_RANGE;
      end
    end else begin
      if (count_q == '0) begin
        status = ST_EMPTY;
      end else if (pos_eff >= cnt_ext) begin
        status = ST_RANGE;
      end
    end
  end

  assign in_acc = in_valid_i && in_ready_o;
  assign do_cmd = in_acc && (status == ST_OK);
  assign op     = !do_cmd ? OP_HOLD : (is_ins ? OP_INSERT : OP_REMOVE);

  always_comb begin
    count_d = count_q;
    if (status == ST_OK) begin
      count_d = is_ins ? (count_q + CW'(1)) : (count_q - CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (in_acc) begin
      count_q <= count_d;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [HANDLE_BITS-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = cell_q[g+1];
    end
    pal_cell #(
      .INDEX       (g),
      .PW          (PW),
      .HANDLE_BITS (HANDLE_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .op_i         (op),
      .pos_i        (pos_eff),
      .new_handle_i (new_handle),
      .left_i       (left),
      .right_i      (right),
      .data_o       (cell_q[g])
    );
  end

  always_comb begin
    sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel = sel | ({HANDLE_BITS{PW'(i) == pos_eff}} & cell_q[i]);
    end
  end

  always_comb begin
    res.removed_handle = '0;
    if ((status == ST_OK) && !is_ins) begin
      res.removed_handle = HANDLE_W'(sel[MINB-1:0]);
    end
    res.status      = status;
    res.entry_count = COUNT_W'(count_d);
  end

  pal_result_buf u_result_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (res),
    .pop_valid_o  (out_valid_o),
    .pop_ready_i  (out_ready_i),
    .pop_data_o   (out_res)
  );

  assign removed_handle_o = out_res.removed_handle;
  assign status_o         = out_res.status;
  assign entry_count_o    = out_res.entry_count;

  `PAL_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(CAPACITY))
  `PAL_ASSERT_NEXT(a_result_ready, in_acc, out_valid_o)
  `PAL_ASSERT_NEXT(a_fail_holds, in_acc && (status != ST_OK), $stable(count_q))
  `PAL_ASSERT_NEXT(a_insert_grows, do_cmd && is_ins, count_q == $past(count_q) + CW'(1))

endmodule
